>>> hdl/glzw_pkg.sv
// Shared types and constants of the GIF LZW decoder.
package glzw_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned MCS_W      = 4;
  // The bit accumulator is 32 bits wide; bits shifted above it are lost.
  localparam int unsigned ACC_W      = 32;
  localparam logic [MCS_W-1:0] MCS_RESET = 4'd8;
  // Largest code width that a clear code can set from the register (15 + 1).
  localparam int unsigned CW_BASE_MAX = 16;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_PULL  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_PIXEL  = 3'd0,
    ST_NEED   = 3'd1,
    ST_ENDED  = 3'd2,
    ST_ERROR  = 3'd3,
    ST_ACCEPT = 3'd4,
    ST_REJECT = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_PULL,
    CMD_START,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [PIX_W-1:0] data_byte;
  } cmd_t;

endpackage

>>> hdl/glzw_if.sv
// Channel interfaces of the GIF LZW decoder: input items, results and configuration.
interface glzw_in_if;
  logic                       valid;
  logic                       ready;
  logic [glzw_pkg::OP_W-1:0]  op;
  logic [glzw_pkg::PIX_W-1:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface glzw_out_if;
  logic                       valid;
  logic                       ready;
  logic [glzw_pkg::ST_W-1:0]  status;
  logic [glzw_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output status, output pixel, input ready);
  modport sink (input valid, input status, input pixel, output ready);
endinterface

interface glzw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [glzw_pkg::MCS_W-1:0] min_code_size;
  modport source (output valid, output min_code_size, input ready);
  modport sink (input valid, input min_code_size, output ready);
endinterface

>>> hdl/glzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/glzw_front.sv
// Front end: accepts input beats, classifies the operation and queues commands.
module glzw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  glzw_in_if.sink        in_i,
  output glzw_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import glzw_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             fifo_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  cmd_t             item;
  logic             push, pop;

  always_comb begin
    item.data_byte = in_i.data_byte;
    case (op_e'(in_i.op))
      OP_BYTE:  item.kind = CMD_BYTE;
      OP_PULL:  item.kind = CMD_PULL;
      OP_START: item.kind = CMD_START;
      default:  item.kind = CMD_NOP;
    endcase
  end

  assign in_i.ready  = (count_q != CNT_W'(DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hdl/glzw_back.sv
// Back end: bit accumulator, code handling, dictionary walk and pixel stack.
module glzw_back #(
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [glzw_pkg::MCS_W-1:0] min_code_size_i,
  input  glzw_pkg::cmd_t             cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  glzw_out_if.source                 out_o
);
  import glzw_pkg::*;

  localparam int unsigned TBL_SIZE  = 1 << MAX_CODE_BITS;
  localparam int unsigned STK_DEPTH = 2 * TBL_SIZE;
  localparam int unsigned IX_W      = MAX_CODE_BITS;
  localparam int unsigned NF_W      = MAX_CODE_BITS + 1;
  localparam int unsigned LIM_W     = MAX_CODE_BITS + 2;
  localparam int unsigned SP_W      = $clog2(STK_DEPTH);
  // Widest code: a clear code may set width 16, then growth adds up to MAX-1.
  localparam int unsigned CODE_W    = CW_BASE_MAX + MAX_CODE_BITS - 1;
  localparam int unsigned CWID_W    = $clog2(CODE_W + 1);
  localparam int unsigned BITS_W    = $clog2(CODE_W + PIX_W);
  localparam int unsigned DICT_W    = IX_W + PIX_W;
  localparam logic [MCS_W-1:0] MCS_MAX  = MCS_W'(MAX_CODE_BITS);
  localparam logic [NF_W-1:0]  ROOT_RST = NF_W'(1) << MCS_RESET;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_LOOP,
    S_WALK
  } state_e;

  state_e             state_q, state_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [BITS_W-1:0]  bits_q, bits_d;
  logic [CWID_W-1:0]  cwid_q, cwid_d;
  logic [NF_W-1:0]    next_free_q, next_free_d;
  logic [LIM_W-1:0]   limit_q, limit_d;
  logic [NF_W-1:0]    root_q, root_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  logic [PIX_W-1:0]   first_char_q, first_char_d;
  logic [CODE_W-1:0]  prev_q, prev_d;
  logic [CODE_W-1:0]  given_q, given_d;
  logic [CODE_W-1:0]  cur_q, cur_d;
  logic [IX_W-1:0]    ix_q, ix_d;
  logic               hit_q, hit_d;
  logic               awaiting_q, awaiting_d;
  logic               ended_q, ended_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;
  logic [ST_W-1:0]    out_status_q, out_status_d;
  logic [PIX_W-1:0]   out_pixel_q, out_pixel_d;

  logic [CODE_W-1:0]  code_mask, code_val, root_ext;
  logic [ACC_W-1:0]   acc_shift;
  logic               have_code, stack_full;
  logic [NF_W-1:0]    nf_inc;
  logic [IX_W-1:0]    loop_ix;
  logic [IX_W-1:0]    walk_pre;
  logic [PIX_W-1:0]   walk_suf;

  logic               st_we, st_re;
  logic [SP_W-1:0]    st_waddr, st_raddr;
  logic [PIX_W-1:0]   st_wdata, st_rdata;
  logic               dict_we, dict_re;
  logic [IX_W-1:0]    dict_waddr, dict_raddr;
  logic [DICT_W-1:0]  dict_wdata, dict_rdata;

  glzw_ram #(.WIDTH(PIX_W), .DEPTH(STK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Each entry holds the prefix code and the suffix byte.
  glzw_ram #(.WIDTH(DICT_W), .DEPTH(TBL_SIZE)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (dict_wdata),
    .re_i    (dict_re),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      code_mask[i] = (CWID_W'(i) < cwid_q);
    end
  end

  assign code_val   = acc_q[CODE_W-1:0] & code_mask;
  assign acc_shift  = acc_q >> cwid_q;
  assign have_code  = (bits_q >= BITS_W'(cwid_q));
  assign stack_full = (sp_q == SP_W'(STK_DEPTH - 1));
  assign root_ext   = CODE_W'(root_q);
  assign nf_inc     = next_free_q + NF_W'(1);
  assign loop_ix    = cur_q[IX_W-1:0];

  // Entries outside the range written since the last rebuild read as prefix zero, suffix the root code or zero.
  assign walk_pre = hit_q ? dict_rdata[DICT_W-1:PIX_W] : '0;
  assign walk_suf = hit_q ? dict_rdata[PIX_W-1:0] :
                    ((NF_W'(ix_q) < root_q) ? ix_q[PIX_W-1:0] : '0);

  assign cmd_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.pixel  = out_pixel_q;

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    bits_d       = bits_q;
    cwid_d       = cwid_q;
    next_free_d  = next_free_q;
    limit_d      = limit_q;
    root_d       = root_q;
    sp_d         = sp_q;
    first_char_d = first_char_q;
    prev_d       = prev_q;
    given_d      = given_q;
    cur_d        = cur_q;
    ix_d         = ix_q;
    hit_d        = hit_q;
    awaiting_d   = awaiting_q;
    ended_d      = ended_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pixel_d  = out_pixel_q;
    st_we        = 1'b0;
    st_waddr     = sp_q;
    st_wdata     = first_char_q;
    st_re        = 1'b0;
    st_raddr     = sp_q - SP_W'(1);
    dict_we      = 1'b0;
    dict_waddr   = next_free_q[IX_W-1:0];
    dict_wdata   = {prev_q[IX_W-1:0], first_char_q};
    dict_re      = 1'b0;
    dict_raddr   = loop_ix;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          out_pixel_d = '0;
          case (cmd_i.kind)
            CMD_START: begin
              acc_d   = '0;
              bits_d  = '0;
              sp_d    = '0;
              ended_d = 1'b0;
              err_d   = 1'b0;
              out_valid_d = 1'b1;
              if (min_code_size_i > MCS_MAX) begin
                err_d        = 1'b1;
                out_status_d = ST_ERROR;
              end else begin
                root_d       = NF_W'(1) << min_code_size_i;
                cwid_d       = CWID_W'(min_code_size_i) + CWID_W'(1);
                next_free_d  = (NF_W'(1) << min_code_size_i) + NF_W'(2);
                limit_d      = LIM_W'(1) << (min_code_size_i + MCS_W'(1));
                awaiting_d   = 1'b1;
                out_status_d = ST_NEED;
              end
            end
            CMD_BYTE: begin
              out_valid_d = 1'b1;
              if (err_q) begin
                out_status_d = ST_ERROR;
              end else if (ended_q) begin
                out_status_d = ST_ENDED;
              end else if ((sp_q != '0) || have_code) begin
                out_status_d = ST_REJECT;
              end else begin
                acc_d        = acc_q | (ACC_W'(cmd_i.data_byte) << bits_q);
                bits_d       = bits_q + BITS_W'(PIX_W);
                out_status_d = ST_ACCEPT;
              end
            end
            CMD_PULL: begin
              state_d = S_CHECK;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_status_d = ST_REJECT;
            end
          endcase
        end
      end

      S_CHECK: begin
        out_pixel_d = '0;
        if (err_q) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_ERROR;
          state_d      = S_IDLE;
        end else if (sp_q != '0) begin
          st_re   = 1'b1;
          sp_d    = sp_q - SP_W'(1);
          state_d = S_POP;
        end else if (ended_q) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_ENDED;
          state_d      = S_IDLE;
        end else if (!have_code) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_NEED;
          state_d      = S_IDLE;
        end else begin
          acc_d  = acc_shift;
          bits_d = bits_q - BITS_W'(cwid_q);
          if (code_val == root_ext) begin
            // A clear code while still awaiting a first code (after a start or a clear) leaves the dictionary alone.
            if (!awaiting_q) begin
              cwid_d      = CWID_W'(min_code_size_i) + CWID_W'(1);
              next_free_d = root_q + NF_W'(2);
              limit_d     = {root_q, 1'b0};
            end
            awaiting_d = 1'b1;
          end else if (code_val == root_ext + CODE_W'(1)) begin
            ended_d = 1'b1;
            acc_d   = '0;
            bits_d  = '0;
          end else if (awaiting_q) begin
            first_char_d = code_val[PIX_W-1:0];
            prev_d       = code_val;
            awaiting_d   = 1'b0;
            out_valid_d  = 1'b1;
            out_status_d = ST_PIXEL;
            out_pixel_d  = code_val[PIX_W-1:0];
            state_d      = S_IDLE;
          end else begin
            given_d = code_val;
            if (code_val >= CODE_W'(next_free_q)) begin
              // Code not yet in the dictionary: previous string plus its first byte.
              if (stack_full) begin
                err_d = 1'b1;
                sp_d  = '0;
              end else begin
                st_we   = 1'b1;
                sp_d    = sp_q + SP_W'(1);
                cur_d   = prev_q;
                state_d = S_LOOP;
              end
            end else begin
              cur_d   = code_val;
              state_d = S_LOOP;
            end
          end
        end
      end

      S_POP: begin
        out_valid_d  = 1'b1;
        out_status_d = ST_PIXEL;
        out_pixel_d  = st_rdata;
        state_d      = S_IDLE;
      end

      S_LOOP: begin
        if (cur_q >= root_ext) begin
          dict_re = 1'b1;
          ix_d    = loop_ix;
          hit_d   = (NF_W'(loop_ix) >= root_q + NF_W'(2)) &&
                    (NF_W'(loop_ix) < next_free_q);
          state_d = S_WALK;
        end else begin
          first_char_d = cur_q[PIX_W-1:0];
          state_d      = S_CHECK;
          if (stack_full) begin
            err_d = 1'b1;
            sp_d  = '0;
          end else begin
            st_we    = 1'b1;
            st_wdata = cur_q[PIX_W-1:0];
            sp_d     = sp_q + SP_W'(1);
            if (next_free_q < NF_W'(TBL_SIZE)) begin
              dict_we     = 1'b1;
              dict_wdata  = {prev_q[IX_W-1:0], cur_q[PIX_W-1:0]};
              next_free_d = nf_inc;
              if ((LIM_W'(nf_inc) >= limit_q) && (limit_q < LIM_W'(TBL_SIZE))) begin
                limit_d = {limit_q[LIM_W-2:0], 1'b0};
                cwid_d  = cwid_q + CWID_W'(1);
              end
            end
            prev_d = given_q;
          end
        end
      end

      S_WALK: begin
        if (stack_full) begin
          err_d   = 1'b1;
          sp_d    = '0;
          state_d = S_CHECK;
        end else begin
          st_we    = 1'b1;
          st_wdata = walk_suf;
          sp_d     = sp_q + SP_W'(1);
          if (cur_q == CODE_W'(walk_pre)) begin
            err_d   = 1'b1;
            sp_d    = '0;
            state_d = S_CHECK;
          end else begin
            cur_d   = CODE_W'(walk_pre);
            state_d = S_LOOP;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      acc_q        <= '0;
      bits_q       <= '0;
      cwid_q       <= CWID_W'(MCS_RESET) + CWID_W'(1);
      next_free_q  <= ROOT_RST + NF_W'(2);
      limit_q      <= {ROOT_RST, 1'b0};
      root_q       <= ROOT_RST;
      sp_q         <= '0;
      first_char_q <= '0;
      prev_q       <= '0;
      given_q      <= '0;
      cur_q        <= '0;
      ix_q         <= '0;
      hit_q        <= 1'b0;
      awaiting_q   <= 1'b0;
      ended_q      <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_pixel_q  <= '0;
    end else begin
      state_q      <= state_d;
      acc_q        <= acc_d;
      bits_q       <= bits_d;
      cwid_q       <= cwid_d;
      next_free_q  <= next_free_d;
      limit_q      <= limit_d;
      root_q       <= root_d;
      sp_q         <= sp_d;
      first_char_q <= first_char_d;
      prev_q       <= prev_d;
      given_q      <= given_d;
      cur_q        <= cur_d;
      ix_q         <= ix_d;
      hit_q        <= hit_d;
      awaiting_q   <= awaiting_d;
      ended_q      <= ended_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_pixel_q  <= out_pixel_d;
    end
  end

endmodule

>>> hdl/gif_lzw_decoder.sv
// GIF LZW decoder top level: input queue, decode engine and configuration register.
// Each input beat gives exactly one result beat, in order. A start, byte or unused
// operation passes through the command queue and then the decode engine, which loads
// the output register. A pull that pops a pixel already on the stack goes from the
// check state to the pop state, with the registered read of the stack memory between
// them. A pull that has to take a new code also walks the dictionary, one registered
// read of the dictionary memory for each link walked, and the pixels it leaves on the
// stack then come out one per pull. The dictionary needs no clearing pass: entries
// beyond the current fill point read as their initial values, so a start or a clear
// code takes effect at once.
module gif_lzw_decoder #(
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  glzw_in_if.sink    in_i,
  glzw_out_if.source out_o,
  glzw_cfg_if.sink   cfg_i
);
  import glzw_pkg::*;

  logic [MCS_W-1:0] mcs_q;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q <= MCS_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      mcs_q <= cfg_i.min_code_size;
    end
  end

  glzw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  glzw_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .min_code_size_i (mcs_q),
    .cmd_i           (cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .out_o           (out_o)
  );

  // The engine takes a command only when no result is waiting in the output register.
  a_pop_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |-> !out_o.valid)
    else $error("command taken while a result beat is still pending");

  // After an input beat is accepted, the command queue shows a valid command on the next cycle.
  a_accept_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd_valid)
    else $error("accepted input beat missing from the command queue");

  a_pixel_zero_otherwise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_PIXEL)) |-> (out_o.pixel == '0))
    else $error("pixel field not zero on a non-pixel result");

endmodule
